>>> sv/srgb_relative_luminance_top_macros.svh
// Assertion macros for the checker file of the luminance block.
// No dependencies; take in with `include by bare file name.
`ifndef SRGB_RELATIVE_LUMINANCE_TOP_MACROS_SVH
`define SRGB_RELATIVE_LUMINANCE_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define SRL_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define SRL_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that stays live through reset.
`define SRL_ASSERT_NXT_ALWAYS(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/srl_pkg.sv
// Package for the sRGB relative luminance block: transfer curve math used
// to build the linearization table at elaboration. No dependencies.
package srl_pkg;

    localparam int Q30_BITS = 30;
    localparam logic [63:0] Q30_ONE = 64'd1 << Q30_BITS;

    // Highest code on the linear segment of the sRGB curve
    localparam logic [7:0] LIN_SEG_MAX = 8'd10;

    // Rec.709 weights, in units of 1/10000
    localparam logic [63:0] KR_E4 = 64'd2126;
    localparam logic [63:0] KG_E4 = 64'd7152;
    localparam logic [63:0] KB_E4 = 64'd722;

    // y^5 in Q0.30, each multiply truncated
    function automatic logic [63:0] fifth_power_q30(input logic [63:0] y);
        logic [63:0] p;
        p = y;
        for (int k = 0; k < 4; k++) begin
            p = (p * y) >> Q30_BITS;
        end
        return p;
    endfunction

    // Linear light value of one 8-bit sRGB code, Q0.30 (0 .. 2^30)
    function automatic logic [63:0] lin_q30(input logic [7:0] c);
        logic [63:0] cw;
        logic [63:0] t;
        logic [63:0] t2;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] mid;
        cw = 64'(c);
        if (c <= LIN_SEG_MAX) begin
            return (64'd100 * cw * Q30_ONE + 64'd164730) / 64'd329460;
        end
        // t = (c/255 + 0.055) / 1.055, then t^2.4 = t^2 * (t^2)^(1/5)
        t  = ((64'd1000 * cw + 64'd14025) * Q30_ONE + 64'd134512) / 64'd269025;
        t2 = (t * t + (Q30_ONE >> 1)) >> Q30_BITS;
        lo = 64'd0;
        hi = Q30_ONE;
        // fifth root by bisection, 32 rounds cover the Q0.30 range
        for (int i = 0; i < 32; i++) begin
            if (lo < hi) begin
                mid = lo + ((hi - lo + 64'd1) >> 1);
                if (fifth_power_q30(mid) <= t2) begin
                    lo = mid;
                end else begin
                    hi = mid - 64'd1;
                end
            end
        end
        return (t2 * lo + (Q30_ONE >> 1)) >> Q30_BITS;
    endfunction

endpackage

>>> sv/srgb_relative_luminance_top.sv
// sRGB relative luminance top level: table lookup, Rec.709 weighting, dark test.
// Depends on srl_pkg (table construction at elaboration).
//
// Takes one 8-bit sRGB pixel per word and returns its relative luminance in
// unsigned Q0.FRAC_BITS (saturated at all ones) plus a dark flag, set when the
// luminance is below the dark_threshold register (reset value 0.3 in
// Q0.FRAC_BITS). The block accepts one pixel every clock while the pipeline is
// not backed up; each word passes through four register stages: table lookup,
// three parallel weight multiplies, the sum with rounding, then saturation and
// the threshold compare into the output register. A stalled output backs up
// the stages one by one, and empty stages keep taking words. Write the
// threshold only while no pixel is in flight.
module srgb_relative_luminance_top #(
    parameter int FRAC_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // pixel input
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [7:0]           i_red_in,
    input  logic [7:0]           i_green_in,
    input  logic [7:0]           i_blue_in,
    // luminance output
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [FRAC_BITS-1:0] o_luminance,
    output logic                 o_dark_flag,
    // threshold register
    input  logic                 i_cfg_wr_en,
    input  logic [FRAC_BITS-1:0] i_cfg_wr_data
);

    localparam int ENT_W  = FRAC_BITS + 1;     // table entry, 0 .. 2^F
    localparam int PROD_W = ENT_W + FRAC_BITS;
    localparam int SUM_W  = PROD_W + 2;
    localparam int SH     = srl_pkg::Q30_BITS - FRAC_BITS;

    localparam logic [63:0] ENT_RND = 64'd1 << (SH - 1);
    localparam logic [FRAC_BITS-1:0] COEF_R =
        FRAC_BITS'(((srl_pkg::KR_E4 << FRAC_BITS) + 64'd5000) / 64'd10000);
    localparam logic [FRAC_BITS-1:0] COEF_G =
        FRAC_BITS'(((srl_pkg::KG_E4 << FRAC_BITS) + 64'd5000) / 64'd10000);
    localparam logic [FRAC_BITS-1:0] COEF_B =
        FRAC_BITS'(((srl_pkg::KB_E4 << FRAC_BITS) + 64'd5000) / 64'd10000);
    localparam logic [FRAC_BITS-1:0] THRESH_RST =
        FRAC_BITS'(((64'd3 << FRAC_BITS) + 64'd5) / 64'd10);
    localparam logic [SUM_W-1:0] SUM_HALF = SUM_W'(1) << (FRAC_BITS - 1);
    localparam logic [FRAC_BITS-1:0] LUM_MAX = '1;

    // Constant linearization table, built at elaboration
    logic [ENT_W-1:0] w_rom [256];

    for (genvar g = 0; g < 256; g++) begin : g_rom
        localparam logic [63:0] Q30 = srl_pkg::lin_q30(8'(g));
        assign w_rom[g] = ENT_W'((Q30 + ENT_RND) >> SH);
    end

    // Threshold register
    logic [FRAC_BITS-1:0] r_dark_threshold;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dark_threshold <= THRESH_RST;
        end else if (i_cfg_wr_en) begin
            r_dark_threshold <= i_cfg_wr_data;
        end
    end

    // Stage valids and per-stage ready
    logic r_v1, r_v2, r_v3, r_v4;
    logic w_rdy1, w_rdy2, w_rdy3, w_rdy4;

    assign w_rdy4 = !r_v4 || i_ready;
    assign w_rdy3 = !r_v3 || w_rdy4;
    assign w_rdy2 = !r_v2 || w_rdy3;
    assign w_rdy1 = !r_v1 || w_rdy2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_rdy1) r_v1 <= i_valid;
            if (w_rdy2) r_v2 <= r_v1;
            if (w_rdy3) r_v3 <= r_v2;
            if (w_rdy4) r_v4 <= r_v3;
        end
    end

    // Datapath
    logic [ENT_W-1:0]     r_lin_r, r_lin_g, r_lin_b;
    logic [PROD_W-1:0]    r_prod_r, r_prod_g, r_prod_b;
    logic [SUM_W-1:0]     r_sum;
    logic [FRAC_BITS-1:0] r_lum;
    logic                 r_dark;

    logic [SUM_W-1:0]          n_sum;
    logic [SUM_W-FRAC_BITS-1:0] w_q;
    logic [FRAC_BITS-1:0]      n_lum;
    logic                      n_dark;

    // sum of weighted terms plus half an LSB for round half up
    assign n_sum = SUM_W'(r_prod_r) + SUM_W'(r_prod_g) + SUM_W'(r_prod_b) + SUM_HALF;

    // drop fraction, saturate at all ones, compare with threshold
    assign w_q    = r_sum[SUM_W-1:FRAC_BITS];
    assign n_lum  = (|w_q[SUM_W-FRAC_BITS-1:FRAC_BITS]) ? LUM_MAX : w_q[FRAC_BITS-1:0];
    assign n_dark = n_lum < r_dark_threshold;

    always_ff @(posedge i_clk) begin
        // stage 1: table lookup
        if (w_rdy1 && i_valid) begin
            r_lin_r <= w_rom[i_red_in];
            r_lin_g <= w_rom[i_green_in];
            r_lin_b <= w_rom[i_blue_in];
        end
        // stage 2: weight multiplies
        if (w_rdy2 && r_v1) begin
            r_prod_r <= PROD_W'(r_lin_r) * PROD_W'(COEF_R);
            r_prod_g <= PROD_W'(r_lin_g) * PROD_W'(COEF_G);
            r_prod_b <= PROD_W'(r_lin_b) * PROD_W'(COEF_B);
        end
        // stage 3: sum
        if (w_rdy3 && r_v2) begin
            r_sum <= n_sum;
        end
        // stage 4: output register
        if (w_rdy4 && r_v3) begin
            r_lum  <= n_lum;
            r_dark <= n_dark;
        end
    end

    assign o_ready     = w_rdy1;
    assign o_valid     = r_v4;
    assign o_luminance = r_lum;
    assign o_dark_flag = r_dark;

endmodule

>>> sv/srl_checker.sv
// Port-level checker for srgb_relative_luminance_top, bound to every instance.
// Depends on srgb_relative_luminance_top_macros.svh.
`include "srgb_relative_luminance_top_macros.svh"

module srl_checker #(
    parameter int FRAC_BITS = 16
) (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_ready,
    input logic                 o_valid,
    input logic                 i_ready,
    input logic [FRAC_BITS-1:0] o_luminance,
    input logic                 o_dark_flag
);

    // reset empties the pipeline
    `SRL_ASSERT_NXT_ALWAYS(a_rst_empty, i_clk, !i_rst_n, !o_valid, "output valid after reset")

    // a stalled word holds its value
    `SRL_ASSERT_NXT(a_stall_hold, i_clk, i_rst_n, o_valid && !i_ready,
        o_valid && $stable(o_luminance) && $stable(o_dark_flag), "stalled word changed")

    // with the output register empty nothing can back up
    `SRL_ASSERT_IMP(a_empty_ready, i_clk, i_rst_n, !o_valid, o_ready,
        "input stalled with empty output")

    // a draining output lets the whole pipeline advance
    `SRL_ASSERT_IMP(a_drain_ready, i_clk, i_rst_n, i_ready, o_ready,
        "input stalled while output drains")

endmodule

bind srgb_relative_luminance_top srl_checker #(.FRAC_BITS(FRAC_BITS)) u_srl_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_ready     (o_ready),
    .o_valid     (o_valid),
    .i_ready     (i_ready),
    .o_luminance (o_luminance),
    .o_dark_flag (o_dark_flag)
);

>>> tb/tb.sv
// Testbench for srgb_relative_luminance_top: random and directed pixel words with
// random idling on both sides, checked against an in-bench luminance predictor.
// Depends on the RTL top level only; the sRGB table is rebuilt here from the curve math.
`timescale 1ns / 100ps

module tb;

    localparam int FRAC = 16;
    localparam int LONG_HOLD = 300;
    localparam logic [15:0] THRESH_AT_RESET = 16'd19661;

    // Rec.709 weights rounded to Q0.16
    localparam logic [63:0] W_RED   = ((64'd2126 << FRAC) + 64'd5000) / 64'd10000;
    localparam logic [63:0] W_GREEN = ((64'd7152 << FRAC) + 64'd5000) / 64'd10000;
    localparam logic [63:0] W_BLUE  = ((64'd722 << FRAC) + 64'd5000) / 64'd10000;
    localparam logic [63:0] ONE_Q30 = 64'd1 << 30;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_pixel;

    typedef struct {
        t_pixel      px;
        logic [15:0] lum;
        logic        dark;
    } t_luma;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_ready;
    logic [7:0]        i_red_in = 8'd0;
    logic [7:0]        i_green_in = 8'd0;
    logic [7:0]        i_blue_in = 8'd0;
    logic              o_valid;
    logic              i_ready = 1'b0;
    logic [FRAC-1:0]   o_luminance;
    logic              o_dark_flag;
    logic              i_cfg_wr_en = 1'b0;
    logic [FRAC-1:0]   i_cfg_wr_data = '0;

    // Linear light per sRGB code, Q0.16 (code 255 gives exactly 1.0)
    logic [16:0]       lin_q16 [256];
    logic [15:0]       thr_model = THRESH_AT_RESET;
    t_pixel            pixel_q [$];
    t_luma             lum_expect [$];
    bit                no_idle = 1'b0;
    int unsigned       send_gap = 0;
    int unsigned       recv_hold = 0;
    int                mismatches = 0;
    int                pixels_sent = 0;
    int                lum_count = 0;
    int                next_long_hold = 30;
    int                long_holds = 0;
    int                thr_settings = 1;

    srgb_relative_luminance_top #(.FRAC_BITS(FRAC)) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_red_in      (i_red_in),
        .i_green_in    (i_green_in),
        .i_blue_in     (i_blue_in),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_luminance   (o_luminance),
        .o_dark_flag   (o_dark_flag),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    always #5 i_clk = ~i_clk;

    // Q0.30 fifth power, each product truncated
    function automatic logic [63:0] pow5_q30(logic [63:0] v);
        logic [63:0] acc;
        acc = v;
        repeat (4) acc = (acc * v) >> 30;
        return acc;
    endfunction

    // sRGB decode of one code to Q0.30: linear toe, else t^2 * fifth_root(t^2)
    function automatic logic [63:0] decode_srgb_q30(int code);
        logic [63:0] c;
        logic [63:0] t;
        logic [63:0] tsq;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] mid;
        c = 64'(code);
        if (code <= 10)
            return (64'd100 * c * ONE_Q30 + 64'd164730) / 64'd329460;
        t = ((64'd1000 * c + 64'd14025) * ONE_Q30 + 64'd134512) / 64'd269025;
        tsq = (t * t + (ONE_Q30 >> 1)) >> 30;
        lo = 64'd0;
        hi = ONE_Q30;
        while (lo < hi) begin
            mid = lo + (hi - lo + 64'd1) / 64'd2;
            if (pow5_q30(mid) <= tsq)
                lo = mid;
            else
                hi = mid - 64'd1;
        end
        return (tsq * lo + (ONE_Q30 >> 1)) >> 30;
    endfunction

    // Weighted sum, round half up, saturate, then dark test
    function automatic t_luma predict_luminance(t_pixel px);
        logic [63:0] acc;
        logic [63:0] rounded;
        t_luma res;
        acc = W_RED * 64'(lin_q16[px.red]) + W_GREEN * 64'(lin_q16[px.green])
            + W_BLUE * 64'(lin_q16[px.blue]);
        rounded = (acc + (64'd1 << (FRAC - 1))) >> FRAC;
        res.px = px;
        res.lum = (rounded > 64'd65535) ? 16'hFFFF : rounded[15:0];
        res.dark = (res.lum < thr_model);
        return res;
    endfunction

    // Idle length: mostly none, some short, a few long
    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Random pixel: mostly uniform, plus grays, toe codes, near white, one channel at an extreme
    function automatic t_pixel rand_pixel();
        t_pixel px;
        int unsigned v;
        px = t_pixel'($urandom);
        case ($urandom_range(0, 9))
            6: begin
                v = $urandom_range(0, 255);
                px = '{8'(v), 8'(v), 8'(v)};
            end
            7: px = '{8'($urandom_range(0, 16)), 8'($urandom_range(0, 16)),
                      8'($urandom_range(0, 16))};
            8: px = '{8'($urandom_range(240, 255)), 8'($urandom_range(240, 255)),
                      8'($urandom_range(240, 255))};
            9: begin
                v = $urandom_range(0, 2);
                if (v == 0) px.red = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                else if (v == 1) px.green = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                else px.blue = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            end
            default: ;
        endcase
        return px;
    endfunction

    task automatic report_mismatch(string what, int got, int want, t_pixel px);
        mismatches++;
        $display("[%0t] MISMATCH %s: got %0d want %0d (rgb %0d,%0d,%0d)",
                 $time, what, got, want, px.red, px.green, px.blue);
    endtask

    task automatic check_luminance();
        t_luma want;
        lum_count++;
        if (lum_expect.size() == 0) begin
            report_mismatch("unexpected word", o_luminance, -1, '0);
        end else begin
            want = lum_expect.pop_front();
            if (o_luminance !== want.lum)
                report_mismatch("luminance", o_luminance, want.lum, want.px);
            if (o_dark_flag !== want.dark)
                report_mismatch("dark_flag", o_dark_flag, want.dark, want.px);
        end
    endtask

    // Sender: offers queued pixels, predicts each one as it is accepted
    always @(posedge i_clk) begin : drive_pixels
        t_pixel px;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            send_gap <= 0;
        end else if (!i_valid || o_ready) begin
            if (i_valid) begin
                lum_expect.push_back(predict_luminance('{i_red_in, i_green_in, i_blue_in}));
                pixels_sent++;
            end
            if (send_gap != 0) begin
                i_valid <= 1'b0;
                send_gap <= send_gap - 1;
            end else if (pixel_q.size() != 0) begin
                px = pixel_q.pop_front();
                i_valid <= 1'b1;
                i_red_in <= px.red;
                i_green_in <= px.green;
                i_blue_in <= px.blue;
                send_gap <= no_idle ? 0 : idle_len();
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Receiver: checks each luminance word; random stalls plus rare long holds
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            recv_hold <= 0;
        end else begin
            if (o_valid && i_ready)
                check_luminance();
            if (lum_count >= next_long_hold) begin
                i_ready <= 1'b0;
                recv_hold <= LONG_HOLD;
                next_long_hold = next_long_hold + 700;
                long_holds++;
            end else if (recv_hold != 0) begin
                i_ready <= 1'b0;
                recv_hold <= recv_hold - 1;
            end else begin
                i_ready <= 1'b1;
                recv_hold <= no_idle ? 0 : idle_len();
            end
        end
    end

    // Wait for the pipeline to empty, plus a few cycles of margin;
    // sampled mid-cycle so the sender's updates have settled
    task automatic wait_drained();
        while (pixel_q.size() != 0 || i_valid || lum_expect.size() != 0)
            @(negedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_threshold(logic [15:0] value);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        thr_model = value;
        thr_settings++;
    endtask

    task automatic queue_random(int count);
        repeat (count) pixel_q.push_back(rand_pixel());
    endtask

    // Stimulus: table build, reset, then threshold phases
    initial begin : stimulus
        t_luma gray;
        for (int c = 0; c < 256; c++)
            lin_q16[c] = 17'((decode_srgb_q30(c) + (64'd1 << 13)) >> 14);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: black, white, primaries, secondaries, toe edge, near white, grays, mixes
        pixel_q.push_back('{8'd0, 8'd0, 8'd0});
        pixel_q.push_back('{8'd255, 8'd255, 8'd255});
        pixel_q.push_back('{8'd255, 8'd0, 8'd0});
        pixel_q.push_back('{8'd0, 8'd255, 8'd0});
        pixel_q.push_back('{8'd0, 8'd0, 8'd255});
        pixel_q.push_back('{8'd10, 8'd10, 8'd10});
        pixel_q.push_back('{8'd11, 8'd11, 8'd11});
        pixel_q.push_back('{8'd10, 8'd11, 8'd10});
        pixel_q.push_back('{8'd1, 8'd0, 8'd0});
        pixel_q.push_back('{8'd0, 8'd1, 8'd0});
        pixel_q.push_back('{8'd0, 8'd0, 8'd1});
        pixel_q.push_back('{8'd254, 8'd255, 8'd255});
        pixel_q.push_back('{8'd255, 8'd254, 8'd255});
        pixel_q.push_back('{8'd255, 8'd255, 8'd254});
        pixel_q.push_back('{8'd254, 8'd254, 8'd254});
        pixel_q.push_back('{8'd0, 8'd255, 8'd255});
        pixel_q.push_back('{8'd255, 8'd255, 8'd0});
        pixel_q.push_back('{8'd128, 8'd128, 8'd128});
        pixel_q.push_back('{8'd149, 8'd149, 8'd149});
        pixel_q.push_back('{8'd150, 8'd150, 8'd150});
        pixel_q.push_back('{8'd170, 8'd85, 8'd42});
        pixel_q.push_back('{8'd85, 8'd170, 8'd213});
        pixel_q.push_back('{8'd12, 8'd9, 8'd200});
        pixel_q.push_back('{8'd255, 8'd255, 8'd255});
        queue_random(300);
        wait_drained();

        // Threshold zero: nothing is dark
        write_threshold(16'd0);
        no_idle = 1'b1;
        pixel_q.push_back('{8'd0, 8'd0, 8'd0});
        queue_random(205);
        wait_drained();

        // Threshold at full scale: everything but saturated white is dark
        write_threshold(16'hFFFF);
        no_idle = 1'b0;
        pixel_q.push_back('{8'd255, 8'd255, 8'd255});
        pixel_q.push_back('{8'd255, 8'd255, 8'd254});
        queue_random(205);
        wait_drained();

        // Threshold equal to mid gray: equality is not dark
        gray = predict_luminance('{8'd128, 8'd128, 8'd128});
        write_threshold(gray.lum);
        pixel_q.push_back('{8'd127, 8'd127, 8'd127});
        pixel_q.push_back('{8'd128, 8'd128, 8'd128});
        pixel_q.push_back('{8'd129, 8'd129, 8'd129});
        queue_random(205);
        wait_drained();

        write_threshold(16'($urandom));
        no_idle = 1'b1;
        queue_random(205);
        wait_drained();

        // Threshold one: only black is dark
        write_threshold(16'd1);
        no_idle = 1'b0;
        pixel_q.push_back('{8'd0, 8'd0, 8'd0});
        pixel_q.push_back('{8'd0, 8'd0, 8'd1});
        queue_random(205);
        wait_drained();

        write_threshold(16'h8000);
        queue_random(100);
        wait_drained();

        write_threshold(THRESH_AT_RESET);
        queue_random(100);
        wait_drained();

        if (lum_expect.size() != 0)
            report_mismatch("words never returned", 0, lum_expect.size(), '0);
        $display("Run covered %0d pixels and %0d luminance words over %0d threshold settings,",
                 pixels_sent, lum_count, thr_settings);
        $display("with %0d long output holds and %0d mismatches.", long_holds, mismatches);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Hard stop well past the slowest legal run
    initial begin
        #10_000_000;
        $display("Timeout at %0t", $time);
        $display("Verification failed");
        $finish;
    end

endmodule

>>> files.f
+incdir+sv
sv/srl_pkg.sv
sv/srgb_relative_luminance_top.sv
sv/srl_checker.sv
tb/tb.sv
